[rtl/core/gbn_pkg.sv]
// Shared types, constants and helper functions for the go-back-n sender window.
// Used by every module under rtl/core except gbn_ram; depends on nothing else.
`default_nettype none

package gbn_pkg;

    // Sequence space and payload storage.
    localparam int SEQ_SPACE    = 8;
    localparam int SEQ_W        = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
    localparam int PAYLOAD_BITS = 64;

    // Fixed field widths of the stream beats.
    localparam int WIN_W       = 3;
    localparam int ACK_W       = 3;
    localparam int SEQ_OUT_W   = 3;
    localparam int DATA_W      = 64;
    localparam int MAX_RESULTS = 7;
    localparam int CNT_W       = 3;

    localparam logic [WIN_W-1:0] WIN_RESET = 3'd4;

    typedef logic [SEQ_W-1:0] seq_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Command codes carried in s_tuser.
    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2
    } cmd_t;

    // Timer request codes.
    typedef enum logic [1:0] {
        TMR_NONE  = 2'd0,
        TMR_START = 2'd1,
        TMR_STOP  = 2'd2
    } timer_t;

    // Operations of the shared modulo unit.
    typedef enum logic {
        OP_SUB = 1'b0,
        OP_ADD = 1'b1
    } seq_op_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    // One result beat handed from the sequencer to the output register.
    typedef struct packed {
        logic                 load;
        logic                 packet_valid;
        logic [SEQ_OUT_W-1:0] seq_num;
        logic [DATA_W-1:0]    packet_data;
        logic                 accepted;
        timer_t               timer_action;
        logic                 last;
    } beat_t;

    // Replay status of the sequencer.
    typedef struct packed {
        logic replaying;
        cnt_t idx;
        cnt_t count;
    } status_t;

    // Reduce a 3-bit acknowledgement number into the sequence space.
    function automatic seq_t seq_of_ack(input logic [ACK_W-1:0] ack);
        logic [8:0] r;
        r = 9'(ack);
        for (int k = 0; k < 4; k++) begin
            if (32'(r) >= SEQ_SPACE) begin
                r = r - 9'(SEQ_SPACE);
            end
        end
        return SEQ_W'(r);
    endfunction

    // Increment modulo the sequence space.
    function automatic seq_t seq_inc(input seq_t s);
        seq_t r;
        if (32'(s) == SEQ_SPACE - 1) begin
            r = '0;
        end else begin
            r = s + SEQ_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/gbn_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the packet store.
`default_nettype none

module gbn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire                                        aclk,
    input  wire                                        we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                           wdata,
    input  wire                                        re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/gbn_seq_unit.sv]
// Shared modulo adder/subtractor over the sequence space.
// Depends on gbn_pkg.
`default_nettype none

module gbn_seq_unit (
    input  wire             op,
    input  gbn_pkg::seq_t   a,
    input  gbn_pkg::seq_t   b,
    output gbn_pkg::seq_t   y
);

    localparam logic [gbn_pkg::SEQ_W:0] SPACE = (gbn_pkg::SEQ_W + 1)'(gbn_pkg::SEQ_SPACE);

    logic [gbn_pkg::SEQ_W:0] sum;

    // One wide add, then a single conditional wrap back into the space.
    always_comb begin
        if (op == gbn_pkg::OP_ADD) begin
            sum = {1'b0, a} + {1'b0, b};
        end else begin
            sum = {1'b0, a} + (SPACE - {1'b0, b});
        end
        if (sum >= SPACE) begin
            sum = sum - SPACE;
        end
        y = gbn_pkg::SEQ_W'(sum);
    end

endmodule

`default_nettype wire

[rtl/core/gbn_ctrl.sv]
// Window sequencer: base and next sequence numbers, window register and the
// replay walk. Depends on gbn_pkg, gbn_seq_unit and gbn_ram.
`default_nettype none

module gbn_ctrl (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_wen,
    input  wire  [gbn_pkg::WIN_W-1:0]   cfg_wdata,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire  [1:0]                  in_cmd,
    input  wire  [gbn_pkg::DATA_W-1:0]  in_payload,
    input  wire  [gbn_pkg::ACK_W-1:0]   in_ack_num,
    input  wire                         in_ack_ok,
    input  wire                         out_free,
    output gbn_pkg::beat_t              beat,
    output gbn_pkg::status_t            status
);

    gbn_pkg::state_t             state_reg, state_next;
    gbn_pkg::seq_t               base_reg, base_next;
    gbn_pkg::seq_t               next_reg, next_next;
    gbn_pkg::cnt_t               idx_reg, idx_next;
    gbn_pkg::cnt_t               count_reg, count_next;
    logic [gbn_pkg::WIN_W-1:0]   win_reg;

    logic                        unit_op;
    gbn_pkg::seq_t               unit_a, unit_b, unit_y;
    logic [gbn_pkg::WIN_W-1:0]   win_eff;
    logic                        accept;
    logic                        full;
    logic                        replay_last;
    gbn_pkg::seq_t               ack_base;

    logic                             ram_we, ram_re;
    logic [gbn_pkg::PAYLOAD_BITS-1:0] ram_rdata;

    // Shared modulo unit: outstanding count while idle, replay address otherwise.
    always_comb begin
        if (state_reg == gbn_pkg::ST_IDLE) begin
            unit_op = gbn_pkg::OP_SUB;
            unit_a  = next_reg;
            unit_b  = base_reg;
        end else begin
            unit_op = gbn_pkg::OP_ADD;
            unit_a  = base_reg;
            unit_b  = gbn_pkg::SEQ_W'(idx_reg);
        end
    end

    gbn_seq_unit u_unit (
        .op (unit_op),
        .a  (unit_a),
        .b  (unit_b),
        .y  (unit_y)
    );

    // Packet store, written on accepted sends and read during replay.
    gbn_ram #(
        .WIDTH (gbn_pkg::PAYLOAD_BITS),
        .DEPTH (gbn_pkg::SEQ_SPACE)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (next_reg),
        .wdata (in_payload[gbn_pkg::PAYLOAD_BITS-1:0]),
        .re    (ram_re),
        .raddr (unit_y),
        .rdata (ram_rdata)
    );

    // Effective window and handshake terms.
    always_comb begin
        if (32'(win_reg) > gbn_pkg::SEQ_SPACE - 1) begin
            win_eff = gbn_pkg::WIN_W'(gbn_pkg::SEQ_SPACE - 1);
        end else begin
            win_eff = win_reg;
        end
        full        = 9'(unit_y) >= 9'(win_eff);
        in_ready    = (state_reg == gbn_pkg::ST_IDLE) && out_free;
        accept      = in_valid && in_ready;
        replay_last = (idx_reg == count_reg - gbn_pkg::CNT_W'(1));
        ack_base    = gbn_pkg::seq_inc(gbn_pkg::seq_of_ack(in_ack_num));
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gbn_pkg::ST_IDLE: begin
                if (accept && (in_cmd == gbn_pkg::CMD_TIMEOUT) && (unit_y != '0)) begin
                    state_next = gbn_pkg::ST_READ;
                end
            end
            gbn_pkg::ST_READ: begin
                state_next = gbn_pkg::ST_EMIT;
            end
            gbn_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = replay_last ? gbn_pkg::ST_IDLE : gbn_pkg::ST_READ;
                end
            end
            default: begin
                state_next = gbn_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and datapath logic.
    always_comb begin
        base_next  = base_reg;
        next_next  = next_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        beat       = '0;
        unique case (state_reg)
            gbn_pkg::ST_IDLE: begin
                if (accept) begin
                    beat.load = 1'b1;
                    beat.last = 1'b1;
                    case (in_cmd)
                        gbn_pkg::CMD_SEND: begin
                            if (!full) begin
                                ram_we            = 1'b1;
                                beat.packet_valid = 1'b1;
                                beat.seq_num      = gbn_pkg::SEQ_OUT_W'(next_reg);
                                beat.packet_data  = in_payload &
                                    gbn_pkg::DATA_W'({gbn_pkg::PAYLOAD_BITS{1'b1}});
                                beat.accepted     = 1'b1;
                                beat.timer_action = (unit_y == '0) ?
                                    gbn_pkg::TMR_START : gbn_pkg::TMR_NONE;
                                next_next         = gbn_pkg::seq_inc(next_reg);
                            end
                        end
                        gbn_pkg::CMD_ACK: begin
                            if (in_ack_ok) begin
                                base_next         = ack_base;
                                beat.accepted     = 1'b1;
                                beat.timer_action = (ack_base == next_reg) ?
                                    gbn_pkg::TMR_STOP : gbn_pkg::TMR_START;
                            end
                        end
                        gbn_pkg::CMD_TIMEOUT: begin
                            // With packets in flight, the replay walk produces the beats.
                            if (unit_y != '0) begin
                                beat.load = 1'b0;
                                idx_next  = '0;
                                if (32'(unit_y) > gbn_pkg::MAX_RESULTS) begin
                                    count_next = gbn_pkg::CNT_W'(gbn_pkg::MAX_RESULTS);
                                end else begin
                                    count_next = gbn_pkg::CNT_W'(unit_y);
                                end
                            end
                        end
                        default: begin
                            beat.last = 1'b1;
                        end
                    endcase
                end
            end
            gbn_pkg::ST_READ: begin
                ram_re = 1'b1;
            end
            gbn_pkg::ST_EMIT: begin
                if (out_free) begin
                    beat.load         = 1'b1;
                    beat.packet_valid = 1'b1;
                    beat.seq_num      = gbn_pkg::SEQ_OUT_W'(unit_y);
                    beat.packet_data  = gbn_pkg::DATA_W'(ram_rdata);
                    beat.timer_action = (idx_reg == '0) ?
                        gbn_pkg::TMR_START : gbn_pkg::TMR_NONE;
                    beat.last         = replay_last;
                    idx_next          = idx_reg + gbn_pkg::CNT_W'(1);
                end
            end
            default: begin
                beat = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gbn_pkg::ST_IDLE;
            base_reg  <= '0;
            next_reg  <= '0;
            idx_reg   <= '0;
            count_reg <= '0;
            win_reg   <= gbn_pkg::WIN_RESET;
        end else begin
            state_reg <= state_next;
            base_reg  <= base_next;
            next_reg  <= next_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (cfg_wen) begin
                win_reg <= cfg_wdata;
            end
        end
    end

    assign status = '{
        replaying: (state_reg != gbn_pkg::ST_IDLE),
        idx:       idx_reg,
        count:     count_reg
    };

endmodule

`default_nettype wire

[rtl/core/go_back_n_sender_window.sv]
// Go-back-n sender window. Send, acknowledgement and unused commands give one
// result beat in the cycle after acceptance; the next command can be taken once the
// output register is free. A timeout with N packets outstanding (at most 7 replayed)
// gives N beats, each waiting on one registered read of the packet store, and no command is taken meanwhile.
// Reset (aresetn low, synchronous) clears base and next sequence number, sets the
// window to 4 and drops the output valid flag; the packet store is not cleared.
`default_nettype none

module go_back_n_sender_window (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_wen,
    input  wire  [gbn_pkg::WIN_W-1:0]  cfg_wdata,   // packets allowed in flight
    input  wire                        s_tvalid,
    output logic                       s_tready,
    input  wire  [71:0]                s_tdata,     // payload[63:0], ack_num[66:64], ack_ok[67]
    input  wire  [1:0]                 s_tuser,     // cmd[1:0]
    output logic                       m_tvalid,
    input  wire                        m_tready,
    output logic [71:0]                m_tdata,     // seq_num[2:0], packet_data[66:3],
                                                    // accepted[67], timer_action[69:68]
    output logic [0:0]                 m_tuser,     // packet_valid[0]
    output logic                       m_tlast      // last
);

    gbn_pkg::beat_t   beat;
    gbn_pkg::status_t status;
    gbn_pkg::beat_t   out_reg;
    logic             m_valid_reg;
    logic             out_free;

    assign out_free = !m_valid_reg || m_tready;

    gbn_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_payload (s_tdata[63:0]),
        .in_ack_num (s_tdata[66:64]),
        .in_ack_ok  (s_tdata[67]),
        .out_free   (out_free),
        .beat       (beat),
        .status     (status)
    );

    // Output register: valid flag under reset, payload loaded with each beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= beat.load;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat.load) begin
            out_reg <= beat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.packet_valid;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {2'b00, out_reg.timer_action, out_reg.accepted,
                       out_reg.packet_data, out_reg.seq_num};

`ifndef ASSERT_OFF
    // Every command other than a timeout answers with one final beat next cycle.
    a_single_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != gbn_pkg::CMD_TIMEOUT) |=> m_tvalid && m_tlast)
        else $error("single-beat command did not produce a final beat");

    // Only replayed packets can be followed by further beats of the same command.
    a_nonlast_is_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[0])
        else $error("non-final beat carries no packet");

    // The replay index stays below the replay count.
    a_replay_index: assert property (@(posedge aclk) disable iff (!aresetn)
        status.replaying |-> (status.idx < status.count))
        else $error("replay index ran past the replay count");

    // No command is taken while the window is being replayed.
    a_replay_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        status.replaying |-> !s_tready)
        else $error("input taken during replay");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the go-back-n sender window: directed and random
// command beats, with the expected result beats worked out by an in-bench window model.
// Depends on gbn_pkg and go_back_n_sender_window.
`timescale 1ns / 100ps

module tb;
    import gbn_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         SETTLE_CYCLES = 2 * MAX_RESULTS + 4;

    typedef struct {
        logic              packet_valid;
        seq_t              seq_num;
        logic [DATA_W-1:0] packet_data;
        logic              accepted;
        timer_t            timer_action;
        logic              last;
    } result_beat_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wen;
    logic [WIN_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [71:0]       s_tdata;   // payload[63:0], ack_num[66:64], ack_ok[67]
    logic [1:0]        s_tuser;   // cmd[1:0]
    logic              m_tvalid;
    logic              m_tready;
    logic [71:0]       m_tdata;   // seq_num[2:0], packet_data[66:3], accepted[67],
                                  // timer_action[69:68]
    logic [0:0]        m_tuser;   // packet_valid[0]
    logic              m_tlast;

    // Window model state, mirrored from the block's point of view.
    logic [WIN_W-1:0]  win_size;
    seq_t              win_base;
    seq_t              nxt_seq;
    logic [DATA_W-1:0] pkt_store [SEQ_SPACE];
    bit                pkt_written [SEQ_SPACE];

    result_beat_t      due_beats [$];
    result_beat_t      want;

    int send_idle_pct;
    int recv_idle_pct;
    int beats_in;
    int beats_out;
    int mismatches;
    int longest_replay;
    int cycle_count;

    go_back_n_sender_window uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Receiver side: stall at random according to the current idle rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Cycle counter that ends a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d result beats still due",
                     cycle_count, due_beats.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, exp_val, act_val);
        end
    endtask

    // Compare every accepted result beat with the oldest one due.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (due_beats.size() == 0) begin
                mismatches++;
                $display("%0t ns: result beat with none due, expected nothing, actual %h",
                         $time, m_tdata);
            end else begin
                want = due_beats.pop_front();
                check_field("packet_valid", 64'(want.packet_valid), 64'(m_tuser[0]));
                check_field("seq_num", 64'(want.seq_num), 64'(m_tdata[2:0]));
                check_field("packet_data", want.packet_data, m_tdata[66:3]);
                check_field("accepted", 64'(want.accepted), 64'(m_tdata[67]));
                check_field("timer_action", 64'(want.timer_action), 64'(m_tdata[69:68]));
                check_field("last", 64'(want.last), 64'(m_tlast));
            end
        end
    end

    function automatic void push_beat(input logic valid, input seq_t seq,
                                      input logic [DATA_W-1:0] data, input logic acc,
                                      input timer_t timer, input logic fin);
        result_beat_t r;
        r.packet_valid = valid;
        r.seq_num      = seq;
        r.packet_data  = data;
        r.accepted     = acc;
        r.timer_action = timer;
        r.last         = fin;
        due_beats.push_back(r);
    endfunction

    // Apply one command to the window model and queue the beats it produces.
    function automatic void advance_window(input logic [1:0] cmd,
                                           input logic [DATA_W-1:0] payload,
                                           input logic [ACK_W-1:0] ack, input logic ok);
        seq_t busy;
        seq_t s;
        int   count;
        // The sequence space is 8, so 3-bit subtraction gives the in-flight count.
        busy = nxt_seq - win_base;
        case (cmd)
            CMD_SEND: begin
                if (busy >= win_size) begin
                    push_beat(1'b0, '0, '0, 1'b0, TMR_NONE, 1'b1);
                end else begin
                    pkt_store[nxt_seq]   = payload;
                    pkt_written[nxt_seq] = 1'b1;
                    push_beat(1'b1, nxt_seq, payload, 1'b1,
                              (busy == 0) ? TMR_START : TMR_NONE, 1'b1);
                    nxt_seq = nxt_seq + seq_t'(1);
                end
            end
            CMD_ACK: begin
                if (!ok) begin
                    push_beat(1'b0, '0, '0, 1'b0, TMR_NONE, 1'b1);
                end else begin
                    win_base = seq_t'(ack + 3'd1);
                    push_beat(1'b0, '0, '0, 1'b1,
                              (win_base == nxt_seq) ? TMR_STOP : TMR_START, 1'b1);
                end
            end
            CMD_TIMEOUT: begin
                if (busy == 0) begin
                    push_beat(1'b0, '0, '0, 1'b0, TMR_NONE, 1'b1);
                end else begin
                    count = (busy > MAX_RESULTS) ? MAX_RESULTS : int'(busy);
                    if (count > longest_replay) longest_replay = count;
                    for (int i = 0; i < count; i++) begin
                        s = win_base + seq_t'(i);
                        push_beat(1'b1, s, pkt_store[s], 1'b0,
                                  (i == 0) ? TMR_START : TMR_NONE, i == count - 1);
                    end
                end
            end
            default: begin
                push_beat(1'b0, '0, '0, 1'b0, TMR_NONE, 1'b1);
            end
        endcase
    endfunction

    // A replay must never read a store entry that was never written.
    function automatic bit replay_safe();
        seq_t busy;
        busy = nxt_seq - win_base;
        for (int i = 0; i < busy && i < MAX_RESULTS; i++) begin
            if (!pkt_written[seq_t'(win_base + seq_t'(i))]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Send one command beat, with a random gap before it.
    task automatic send_beat(input logic [1:0] cmd, input logic [DATA_W-1:0] payload,
                             input logic [ACK_W-1:0] ack, input logic ok);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, ok, ack, payload};
        s_tuser  <= cmd;
        advance_window(cmd, payload, ack, ok);
        beats_in++;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the sender until every due beat has come out and the block is quiet.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (due_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] w);
        wait_drained();
        cfg_wdata <= w;
        cfg_wen   <= 1'b1;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        win_size  = w;
    endtask

    // Commands that find nothing to do.
    task automatic test_idle_commands();
        send_beat(CMD_TIMEOUT, '0, '0, 1'b0);
        send_beat(CMD_UNUSED, '1, 3'd7, 1'b1);
        send_beat(CMD_ACK, 64'h0123_4567_89ab_cdef, 3'd7, 1'b0);
    endtask

    // Fill the reset window of four, get refused, replay, then acknowledge.
    task automatic test_fill_and_refuse();
        send_beat(CMD_SEND, 64'h0, 3'd0, 1'b0);
        send_beat(CMD_SEND, 64'hffff_ffff_ffff_ffff, 3'd7, 1'b1);
        send_beat(CMD_SEND, 64'haaaa_aaaa_aaaa_aaaa, 3'd2, 1'b0);
        send_beat(CMD_SEND, 64'h5555_5555_5555_5555, 3'd5, 1'b1);
        send_beat(CMD_SEND, 64'hdead_beef_0000_0001, 3'd0, 1'b0);
        send_beat(CMD_TIMEOUT, '0, '0, 1'b0);
        send_beat(CMD_ACK, '0, 3'd1, 1'b1);
        send_beat(CMD_ACK, '0, 3'd3, 1'b1);
    endtask

    // Largest window: seven in flight across the wrap, and a seven-packet replay.
    task automatic test_replay_full_window();
        set_window(3'd7);
        for (int i = 0; i < 7; i++) begin
            send_beat(CMD_SEND, {$urandom, $urandom}, 3'($urandom_range(7)), 1'b0);
        end
        send_beat(CMD_SEND, {$urandom, $urandom}, 3'd0, 1'b0);
        send_beat(CMD_TIMEOUT, '0, '0, 1'b0);
        send_beat(CMD_ACK, '0, 3'd2, 1'b1);
    endtask

    // A window of zero refuses everything; a window of one allows one packet.
    task automatic test_small_windows();
        set_window(3'd0);
        send_beat(CMD_SEND, {$urandom, $urandom}, 3'd0, 1'b0);
        set_window(3'd1);
        send_beat(CMD_SEND, {$urandom, $urandom}, 3'd0, 1'b0);
        send_beat(CMD_SEND, {$urandom, $urandom}, 3'd0, 1'b0);
        send_beat(CMD_ACK, '0, 3'd3, 1'b1);
        // An acknowledgement that moves the base backward leaves three in flight.
        send_beat(CMD_ACK, '0, 3'd0, 1'b1);
        send_beat(CMD_TIMEOUT, '0, '0, 1'b0);
    endtask

    // Mostly well-formed traffic with random content, plus some noise.
    task automatic run_random_traffic(input int n, input logic [WIN_W-1:0] w);
        int                pick;
        seq_t              busy;
        logic [DATA_W-1:0] data;
        logic [ACK_W-1:0]  ack;
        logic              ok;
        set_window(w);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) wait_drained();
            pick = $urandom_range(99);
            busy = nxt_seq - win_base;
            data = {$urandom, $urandom};
            ack  = 3'($urandom_range(7));
            ok   = 1'($urandom_range(1));
            if (pick < 45) begin
                send_beat(CMD_SEND, data, ack, ok);
            end else if (pick < 75) begin
                // Acknowledge somewhere inside the packets in flight.
                send_beat(CMD_ACK, data, 3'(win_base - 1 + $urandom_range(busy)), 1'b1);
            end else if (pick < 87) begin
                if (replay_safe()) begin
                    send_beat(CMD_TIMEOUT, data, ack, ok);
                end else begin
                    send_beat(CMD_ACK, data, 3'(nxt_seq - 1), 1'b1);
                end
            end else if (pick < 92) begin
                send_beat(CMD_ACK, data, ack, 1'b0);
            end else if (pick < 96) begin
                send_beat(CMD_ACK, data, ack, 1'b1);
            end else begin
                send_beat(CMD_UNUSED, data, ack, ok);
            end
        end
    endtask

    initial begin
        aresetn        <= 1'b0;
        cfg_wen        <= 1'b0;
        cfg_wdata      <= '0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= '0;
        m_tready       <= 1'b0;
        win_size       = WIN_RESET;
        win_base       = '0;
        nxt_seq        = '0;
        beats_in       = 0;
        beats_out      = 0;
        mismatches     = 0;
        longest_replay = 0;
        cycle_count    = 0;
        send_idle_pct  = 19;
        recv_idle_pct  = 88;
        for (int i = 0; i < SEQ_SPACE; i++) pkt_written[i] = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_commands();
        test_fill_and_refuse();
        test_replay_full_window();
        test_small_windows();

        run_random_traffic(120, 3'd3);
        send_idle_pct = 88;
        recv_idle_pct = 19;
        run_random_traffic(115, 3'd7);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_traffic(115, 3'd5);

        wait_drained();
        $display("Covered %0d command beats and %0d result beats over windows of 0, 1, 3,",
                 beats_in, beats_out);
        $display("4, 5 and 7, with replays of up to %0d packets and %0d mismatches.",
                 longest_replay, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/gbn_pkg.sv
rtl/core/gbn_ram.sv
rtl/core/gbn_seq_unit.sv
rtl/core/gbn_ctrl.sv
rtl/core/go_back_n_sender_window.sv
tb/tb.sv
